>>> rtl/fjq_pkg.sv
package fjq_pkg;

    // Default configuration of the queue.
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int MAX_DURATION_DEF = 15;

    // Fixed field widths.
    localparam int ID_W    = 16;
    localparam int TICK_W  = 32;
    localparam int DUR_W   = 4;
    localparam int QCNT_W  = 5;
    localparam int DONE_W  = 32;
    localparam int WAIT_W  = 48;

    // One stored job: id, arrival tick and (clamped) service duration.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] arrival;
        logic [DUR_W-1:0]  duration;
    } t_job_entry;

endpackage

>>> rtl/fjq_if.sv
interface fjq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      job_arrives;
    logic [fjq_pkg::DUR_W-1:0] job_duration;

    modport source (output valid, output job_arrives, output job_duration, input ready);
    modport sink   (input valid, input job_arrives, input job_duration, output ready);
endinterface

interface fjq_out_if;
    logic                       valid;
    logic                       ready;
    logic                       job_started;
    logic                       server_busy;
    logic [fjq_pkg::ID_W-1:0]   serving_id;
    logic [fjq_pkg::QCNT_W-1:0] queue_count;
    logic                       arrival_dropped;
    logic [fjq_pkg::DONE_W-1:0] jobs_done;
    logic [fjq_pkg::WAIT_W-1:0] wait_total;

    modport source (
        output valid, output job_started, output server_busy, output serving_id,
        output queue_count, output arrival_dropped, output jobs_done, output wait_total,
        input ready
    );
    modport sink (
        input valid, input job_started, input server_busy, input serving_id,
        input queue_count, input arrival_dropped, input jobs_done, input wait_total,
        output ready
    );
endinterface

>>> rtl/fifo_job_queue_single_server.sv
// Single-server FIFO job queue. Every input transaction is one time tick that
// may carry an arriving job with its service duration; every tick yields exactly
// one result transaction describing the queue and the server after that tick.
// Each tick passes through the sequencer states ST_IDLE and ST_FIN: in the first the arriving job is written to
// the job memory and the head entry is read, and in the second the registered
// read data comes back and the head job starts if the server is idle. The job
// memory read is registered, which is why ST_FIN is needed, and a new tick is
// taken only back in ST_IDLE. When the queue is empty and a job arrives, the written
// entry is forwarded so the job can start in the same tick with zero wait. A
// finished result sits in an output register, so the next tick is accepted while
// it waits; only the completing cycle stalls while the output register is still
// full. A full queue drops the arriving job (it still consumes an id). The
// job-done count and the wait total saturate; ids and ticks wrap.
module fifo_job_queue_single_server #(
    parameter int QUEUE_DEPTH  = fjq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_DURATION = fjq_pkg::MAX_DURATION_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fjq_in_if.sink      i_job,
    fjq_out_if.source   o_res
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [7:0]    MAX_DUR  = 8'(MAX_DURATION);

    // Sequencer states.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIN  = 1'b1;

    // Control and architectural state.
    logic                        r_state,        n_state;
    logic [IW-1:0]               r_head,         n_head;
    logic [IW-1:0]               r_tail,         n_tail;
    logic [CW-1:0]               r_count,        n_count;
    logic [fjq_pkg::TICK_W-1:0]  r_tick,         n_tick;
    logic [fjq_pkg::ID_W-1:0]    r_next_id,      n_next_id;
    logic [fjq_pkg::DUR_W-1:0]   r_service_left, n_service_left;
    logic [fjq_pkg::ID_W-1:0]    r_current_id,   n_current_id;
    logic [fjq_pkg::DONE_W-1:0]  r_started,      n_started;
    logic [fjq_pkg::WAIT_W-1:0]  r_wait_sum,     n_wait_sum;
    logic                        r_out_valid,    n_out_valid;

    // Per-tick bookkeeping carried from ST_IDLE into ST_FIN.
    logic                        r_pop,          n_pop;
    logic                        r_use_fwd,      n_use_fwd;
    logic                        r_dropped,      n_dropped;
    logic [fjq_pkg::TICK_W-1:0]  r_tick_now,     n_tick_now;
    fjq_pkg::t_job_entry         r_fwd,          n_fwd;

    // Result register payload.
    logic                        r_o_started,    n_o_started;
    logic                        r_o_busy,       n_o_busy;
    logic [fjq_pkg::QCNT_W-1:0]  r_o_qcount,     n_o_qcount;
    logic                        r_o_dropped,    n_o_dropped;

    // Job memory ports.
    fjq_pkg::t_job_entry job_mem [QUEUE_DEPTH];
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    fjq_pkg::t_job_entry mem_wd;
    logic                mem_re;
    fjq_pkg::t_job_entry r_mem_rd;

    // Working signals.
    logic                          accept;
    logic                          out_free;
    logic                          push;
    logic [fjq_pkg::DUR_W-1:0]     dur_clamped;
    logic [CW-1:0]                 count_after_push;
    fjq_pkg::t_job_entry           head_entry;
    logic [fjq_pkg::TICK_W-1:0]    wait_ticks;
    logic [fjq_pkg::WAIT_W:0]      wait_add;
    logic [CW+fjq_pkg::QCNT_W-1:0] count_ext;

    assign accept   = (r_state == ST_IDLE) && i_job.valid;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_job.ready = (r_state == ST_IDLE);

    assign o_res.valid           = r_out_valid;
    assign o_res.job_started     = r_o_started;
    assign o_res.server_busy     = r_o_busy;
    assign o_res.serving_id      = r_current_id;
    assign o_res.queue_count     = r_o_qcount;
    assign o_res.arrival_dropped = r_o_dropped;
    assign o_res.jobs_done       = r_started;
    assign o_res.wait_total      = r_wait_sum;

    // Durations above the configured maximum are clamped.
    always_comb begin
        if ({4'b0000, i_job.job_duration} > MAX_DUR) begin
            dur_clamped = MAX_DUR[fjq_pkg::DUR_W-1:0];
        end else begin
            dur_clamped = i_job.job_duration;
        end
    end

    assign push             = i_job.job_arrives && (r_count != FULL_CNT);
    assign count_after_push = r_count + CW'(push);

    // The memory write and the forwarded copy use the same entry; the head read uses r_head.
    assign mem_we = accept && push;
    assign mem_wa = r_tail;
    assign mem_wd = '{id: r_next_id + 16'd1, arrival: r_tick, duration: dur_clamped};
    assign mem_re = accept;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            job_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_rd <= job_mem[r_head];
        end
    end

    // Head entry of the pop: forwarded when the queue was empty before the push.
    assign head_entry = r_use_fwd ? r_fwd : r_mem_rd;
    assign wait_ticks = r_tick_now - head_entry.arrival;
    assign wait_add   = {1'b0, r_wait_sum} + {17'd0, wait_ticks};

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_tick         = r_tick;
        n_next_id      = r_next_id;
        n_service_left = r_service_left;
        n_current_id   = r_current_id;
        n_started      = r_started;
        n_wait_sum     = r_wait_sum;
        n_out_valid    = r_out_valid;
        n_pop          = r_pop;
        n_use_fwd      = r_use_fwd;
        n_dropped      = r_dropped;
        n_tick_now     = r_tick_now;
        n_fwd          = r_fwd;
        n_o_started    = r_o_started;
        n_o_busy       = r_o_busy;
        n_o_qcount     = r_o_qcount;
        n_o_dropped    = r_o_dropped;
        count_ext      = '0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Arrival: take an id, then push or drop.
                    if (i_job.job_arrives) begin
                        n_next_id = r_next_id + 16'd1;
                    end
                    if (push) begin
                        n_tail = (r_tail == LAST_IDX) ? '0 : r_tail + IW'(1);
                    end
                    n_count    = count_after_push;
                    n_dropped  = i_job.job_arrives && !push;
                    n_pop      = (r_service_left == '0) && (count_after_push != '0);
                    n_use_fwd  = push && (r_count == '0);
                    n_fwd      = mem_wd;
                    n_tick_now = r_tick;
                    n_tick     = r_tick + 32'd1;
                    n_state    = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (r_pop) begin
                        n_head       = (r_head == LAST_IDX) ? '0 : r_head + IW'(1);
                        n_count      = r_count - CW'(1);
                        n_current_id = head_entry.id;
                        n_service_left = (head_entry.duration != '0)
                                       ? head_entry.duration - 4'd1 : '0;
                        n_wait_sum   = wait_add[fjq_pkg::WAIT_W] ? '1
                                     : wait_add[fjq_pkg::WAIT_W-1:0];
                        if (r_started != '1) begin
                            n_started = r_started + 32'd1;
                        end
                    end else if (r_service_left != '0) begin
                        n_service_left = r_service_left - 4'd1;
                    end
                    count_ext   = {{fjq_pkg::QCNT_W{1'b0}}, n_count};
                    n_o_started = r_pop;
                    n_o_busy    = (n_service_left != '0);
                    n_o_qcount  = count_ext[fjq_pkg::QCNT_W-1:0];
                    n_o_dropped = r_dropped;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_tick         <= '0;
            r_next_id      <= '0;
            r_service_left <= '0;
            r_current_id   <= '0;
            r_started      <= '0;
            r_wait_sum     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_tick         <= n_tick;
            r_next_id      <= n_next_id;
            r_service_left <= n_service_left;
            r_current_id   <= n_current_id;
            r_started      <= n_started;
            r_wait_sum     <= n_wait_sum;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop       <= n_pop;
        r_use_fwd   <= n_use_fwd;
        r_dropped   <= n_dropped;
        r_tick_now  <= n_tick_now;
        r_fwd       <= n_fwd;
        r_o_started <= n_o_started;
        r_o_busy    <= n_o_busy;
        r_o_qcount  <= n_o_qcount;
        r_o_dropped <= n_o_dropped;
    end

endmodule

>>> dv/tb_fifo_job_queue_single_server.sv
`timescale 1ns / 1ps

module tb_fifo_job_queue_single_server;

    localparam int DEPTH         = fjq_pkg::QUEUE_DEPTH_DEF;
    localparam int LONGEST_JOB   = fjq_pkg::MAX_DURATION_DEF;
    localparam int RANDOM_TICKS  = 1900;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 12;

    // Kinds of traffic in the random part. A flood overruns the server so the
    // queue fills and arrivals get dropped, a trickle lets it drain again, and
    // a mix sits in between.
    typedef enum int {
        TRAFFIC_FLOOD,
        TRAFFIC_TRICKLE,
        TRAFFIC_MIXED
    } t_traffic;

    // What the block reports after one tick.
    typedef struct packed {
        logic                       job_started;
        logic                       server_busy;
        logic [fjq_pkg::ID_W-1:0]   serving_id;
        logic [fjq_pkg::QCNT_W-1:0] queue_count;
        logic                       arrival_dropped;
        logic [fjq_pkg::DONE_W-1:0] jobs_done;
        logic [fjq_pkg::WAIT_W-1:0] wait_total;
    } t_tick_report;

    // One tick of stimulus. Rows that are pinned carry a report typed in by
    // hand; all others are judged by the queue model below.
    typedef struct {
        logic                      arrives;
        logic [fjq_pkg::DUR_W-1:0] duration;
        bit                        pinned;
        t_tick_report              report;
    } t_tick_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fjq_in_if  job_if ();
    fjq_out_if res_if ();

    fifo_job_queue_single_server dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Queue model. It keeps its own copy of the queue and the counters and
    // moves one tick forward for every accepted input transaction.
    // ------------------------------------------------------------------
    fjq_pkg::t_job_entry        model_waiting[$];
    logic [fjq_pkg::TICK_W-1:0] model_tick = '0;
    logic [fjq_pkg::ID_W-1:0]   model_next_id = '0;
    logic [fjq_pkg::DUR_W-1:0]  model_service_left = '0;
    logic [fjq_pkg::ID_W-1:0]   model_current_id = '0;
    logic [fjq_pkg::DONE_W-1:0] model_started = '0;
    logic [fjq_pkg::WAIT_W-1:0] model_wait_sum = '0;

    function automatic t_tick_report advance_queue_tick(
            logic arrives, logic [fjq_pkg::DUR_W-1:0] duration_in);
        t_tick_report               rep;
        fjq_pkg::t_job_entry        job;
        logic [fjq_pkg::DUR_W-1:0]  duration;
        logic [fjq_pkg::TICK_W-1:0] waited;
        logic [fjq_pkg::WAIT_W:0]   sum;
        rep = '0;
        duration = (int'(duration_in) > LONGEST_JOB) ? fjq_pkg::DUR_W'(LONGEST_JOB)
                                                     : duration_in;

        // The arrival is handled first: it takes an id even when it is dropped.
        if (arrives) begin
            model_next_id = model_next_id + 1'b1;
            if (model_waiting.size() >= DEPTH) begin
                rep.arrival_dropped = 1'b1;
            end else begin
                job.id       = model_next_id;
                job.arrival  = model_tick;
                job.duration = duration;
                model_waiting.push_back(job);
            end
        end

        // Then an idle server takes the head job, which may be the one that
        // just arrived.
        if (model_service_left == '0) begin
            if (model_waiting.size() > 0) begin
                job = model_waiting.pop_front();
                model_current_id = job.id;
                model_service_left = (job.duration != '0) ? job.duration - 1'b1 : '0;
                waited = model_tick - job.arrival;
                sum = {1'b0, model_wait_sum}
                    + {{(fjq_pkg::WAIT_W - fjq_pkg::TICK_W + 1){1'b0}}, waited};
                model_wait_sum = sum[fjq_pkg::WAIT_W] ? '1 : sum[fjq_pkg::WAIT_W-1:0];
                if (model_started != '1) begin
                    model_started = model_started + 1'b1;
                end
                rep.job_started = 1'b1;
            end
        end else begin
            model_service_left = model_service_left - 1'b1;
        end

        model_tick = model_tick + 1'b1;

        rep.server_busy = (model_service_left != '0);
        rep.serving_id  = model_current_id;
        rep.queue_count = fjq_pkg::QCNT_W'(model_waiting.size());
        rep.jobs_done   = model_started;
        rep.wait_total  = model_wait_sum;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping between the drivers and the monitor.
    // ------------------------------------------------------------------
    t_tick_row    offered_rows[$];     // rows on the input, oldest first
    t_tick_report pending_reports[$];  // reports the block still owes
    int           mismatch_count = 0;
    int           ticks_accepted = 0;
    int           reports_checked = 0;
    int           arrivals_seen = 0;
    int           drops_seen = 0;
    int           starts_seen = 0;
    int           fullest_queue = 0;
    bit           quiet_phase = 1'b0;  // both sides stop idling while set
    bit           hold_request = 1'b0; // asks the receiver for a long hold-off
    int           holds_done = 0;

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // The monitor samples both channels at the rising edge, before any of this
    // edge's nonblocking updates land, so it sees exactly what the block saw.
    always @(posedge i_clk) begin
        t_tick_row    row;
        t_tick_report rep;
        t_tick_report got;
        if (i_rst_n) begin
            if (job_if.valid && job_if.ready) begin
                row = offered_rows.pop_front();
                rep = advance_queue_tick(job_if.job_arrives, job_if.job_duration);
                // A pinned row still advances the model, so the rows that follow
                // are predicted from the right state.
                pending_reports.push_back(row.pinned ? row.report : rep);
                ticks_accepted++;
                arrivals_seen += int'(job_if.job_arrives);
                drops_seen += int'(rep.arrival_dropped);
                starts_seen += int'(rep.job_started);
                if (int'(rep.queue_count) > fullest_queue) begin
                    fullest_queue = int'(rep.queue_count);
                end
            end

            if (res_if.valid && res_if.ready) begin
                got.job_started     = res_if.job_started;
                got.server_busy     = res_if.server_busy;
                got.serving_id      = res_if.serving_id;
                got.queue_count     = res_if.queue_count;
                got.arrival_dropped = res_if.arrival_dropped;
                got.jobs_done       = res_if.jobs_done;
                got.wait_total      = res_if.wait_total;
                if (pending_reports.size() == 0) begin
                    $error("result transaction with no tick waiting for it");
                    mismatch_count++;
                end else begin
                    rep = pending_reports.pop_front();
                    check_field("job_started", 64'(rep.job_started),
                                64'(got.job_started));
                    check_field("server_busy", 64'(rep.server_busy),
                                64'(got.server_busy));
                    check_field("serving_id", 64'(rep.serving_id),
                                64'(got.serving_id));
                    check_field("queue_count", 64'(rep.queue_count),
                                64'(got.queue_count));
                    check_field("arrival_dropped", 64'(rep.arrival_dropped),
                                64'(got.arrival_dropped));
                    check_field("jobs_done", 64'(rep.jobs_done), 64'(got.jobs_done));
                    check_field("wait_total", 64'(rep.wait_total), 64'(got.wait_total));
                    reports_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Before every result it stalls for a random number of cycles,
    // none during a quiet phase. When asked, it holds off for a long stretch
    // so that the block's output backs up and its input stalls.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
                holds_done++;
            end else begin
                stall = quiet_phase ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender. Each tick waits a random gap, then stays offered until the
    // block takes it. A tick that follows at once replaces the payload in the
    // same edge without dropping valid.
    // ------------------------------------------------------------------
    task automatic offer_tick(t_tick_row row);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            job_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_rows.push_back(row);
        job_if.valid        <= 1'b1;
        job_if.job_arrives  <= row.arrives;
        job_if.job_duration <= row.duration;
        @(posedge i_clk);
        while (!job_if.ready) @(posedge i_clk);
    endtask

    function automatic t_tick_row plain_row(logic arrives,
                                            logic [fjq_pkg::DUR_W-1:0] duration);
        t_tick_row row;
        row.arrives  = arrives;
        row.duration = duration;
        row.pinned   = 1'b0;
        row.report   = '0;
        return row;
    endfunction

    function automatic t_tick_row pinned_row(logic arrives,
                                             logic [fjq_pkg::DUR_W-1:0] duration,
                                             t_tick_report report);
        t_tick_row row;
        row = plain_row(arrives, duration);
        row.pinned = 1'b1;
        row.report = report;
        return row;
    endfunction

    // Draws one random tick for the given kind of traffic. Durations of zero
    // appear now and then in every kind; idle ticks carry noise in the
    // duration field, which the block must ignore.
    function automatic t_tick_row random_row(t_traffic kind);
        logic                      arrives;
        logic [fjq_pkg::DUR_W-1:0] duration;
        case (kind)
            TRAFFIC_FLOOD: begin
                arrives  = ($urandom_range(0, 9) != 0);
                duration = ($urandom_range(0, 15) == 0) ? '0
                         : fjq_pkg::DUR_W'($urandom_range(6, 15));
            end
            TRAFFIC_TRICKLE: begin
                arrives  = ($urandom_range(0, 9) == 0);
                duration = fjq_pkg::DUR_W'($urandom_range(0, 15));
            end
            default: begin
                arrives  = 1'($urandom_range(0, 1));
                duration = fjq_pkg::DUR_W'($urandom_range(0, 15));
            end
        endcase
        return plain_row(arrives, duration);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence: reset, directed ticks, random traffic, drain, verdict.
    // ------------------------------------------------------------------
    initial begin
        t_tick_row    directed_rows[$];
        t_tick_report rep;
        t_traffic     kind;
        int           burst_len;
        int           random_sent;

        job_if.valid        <= 1'b0;
        job_if.job_arrives  <= 1'b0;
        job_if.job_duration <= '0;

        // Directed ticks. The first rows and the first drop are simple enough
        // to type in; the rows that fill the queue are left to the model.
        // An empty tick right after reset reports nothing at all.
        directed_rows.push_back(pinned_row(1'b0, 4'd0, '0));
        // A zero-length job arrives on an idle server: it starts at once with
        // no wait and leaves the server idle.
        rep = '0;
        rep.job_started = 1'b1; rep.serving_id = 16'd1; rep.jobs_done = 32'd1;
        directed_rows.push_back(pinned_row(1'b1, 4'd0, rep));
        // The next job again finds the server free in the same tick.
        rep.serving_id = 16'd2; rep.jobs_done = 32'd2;
        directed_rows.push_back(pinned_row(1'b1, 4'd1, rep));
        // The longest job occupies the server for the following fourteen ticks.
        rep.server_busy = 1'b1; rep.serving_id = 16'd3; rep.jobs_done = 32'd3;
        directed_rows.push_back(pinned_row(1'b1, 4'd15, rep));
        // Arrivals pile up behind it. The first of them is long too, so the
        // queue reaches its depth before the server frees up again.
        directed_rows.push_back(plain_row(1'b1, 4'd15));
        directed_rows.push_back(plain_row(1'b1, 4'd1));
        directed_rows.push_back(plain_row(1'b1, 4'd7));
        directed_rows.push_back(plain_row(1'b1, 4'd0));
        directed_rows.push_back(plain_row(1'b1, 4'd3));
        directed_rows.push_back(plain_row(1'b1, 4'd9));
        directed_rows.push_back(plain_row(1'b1, 4'd12));
        directed_rows.push_back(plain_row(1'b1, 4'd5));
        directed_rows.push_back(plain_row(1'b1, 4'd15));
        directed_rows.push_back(plain_row(1'b1, 4'd2));
        directed_rows.push_back(plain_row(1'b1, 4'd11));
        directed_rows.push_back(plain_row(1'b1, 4'd6));
        directed_rows.push_back(plain_row(1'b1, 4'd14));
        directed_rows.push_back(plain_row(1'b1, 4'd10));
        // The server takes job 4 here, after a wait of fourteen ticks, in the
        // same tick as another arrival is pushed.
        directed_rows.push_back(plain_row(1'b1, 4'd8));
        directed_rows.push_back(plain_row(1'b1, 4'd4));
        directed_rows.push_back(plain_row(1'b1, 4'd13));
        // The queue is full now: this arrival is dropped but uses up id 21.
        rep = '0;
        rep.server_busy = 1'b1; rep.serving_id = 16'd4; rep.queue_count = 5'd16;
        rep.arrival_dropped = 1'b1; rep.jobs_done = 32'd4; rep.wait_total = 48'd14;
        directed_rows.push_back(pinned_row(1'b1, 4'd15, rep));
        directed_rows.push_back(plain_row(1'b1, 4'd1));
        // An idle tick with every bit of the duration set must be ignored.
        directed_rows.push_back(plain_row(1'b0, 4'd15));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            offer_tick(directed_rows[i]);
        end

        // Random traffic in bursts. Each burst picks a kind of traffic and
        // whether both sides run without idling. The first two floods also
        // ask the receiver for a long hold-off while the sender keeps going.
        random_sent = 0;
        while (random_sent < RANDOM_TICKS) begin
            kind = t_traffic'($urandom_range(0, 2));
            burst_len = $urandom_range(20, 80);
            quiet_phase = ($urandom_range(0, 3) == 0);
            if (kind == TRAFFIC_FLOOD && holds_done < 2 && !hold_request) begin
                hold_request = 1'b1;
            end
            for (int i = 0; i < burst_len && random_sent < RANDOM_TICKS; i++) begin
                offer_tick(random_row(kind));
                random_sent++;
            end
        end
        job_if.valid <= 1'b0;
        quiet_phase = 1'b0;

        // Let the monitor log the last accepted tick, wait for every report
        // still owed, then give the block a few more cycles to show anything
        // it should not send.
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d ticks with %0d arrivals, %0d job starts and %0d drops.",
                 ticks_accepted, arrivals_seen, starts_seen, drops_seen);
        $display("Queue reached %0d jobs; %0d reports checked, %0d long receiver holds.",
                 fullest_queue, reports_checked, holds_done);
        if (mismatch_count == 0) begin
            $display("tb_fifo_job_queue_single_server: PASS");
        end else begin
            $display("tb_fifo_job_queue_single_server: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #16_000_000;
        $display("tb_fifo_job_queue_single_server: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fjq_pkg.sv
rtl/fjq_if.sv
rtl/fifo_job_queue_single_server.sv
dv/tb_fifo_job_queue_single_server.sv
